@@ hdl/gpioed_pkg.sv @@
package gpioed_pkg;

    localparam int NUM_PINS_DEFAULT = 54;
    localparam int PINS_PER_FSEL    = 10;
    localparam int FSEL_WORDS       = 6;
    localparam int FSEL_PINS        = FSEL_WORDS * PINS_PER_FSEL;
    localparam int FSEL_BITS        = 3 * PINS_PER_FSEL;

    localparam logic [2:0] FSEL_OUTPUT   = 3'd1;
    localparam logic [1:0] PULL_DOWN     = 2'd1;
    localparam logic [1:0] PULL_UP       = 2'd2;

    // word offsets
    localparam logic [5:0] ADDR_FSEL_FIRST = 6'd0;
    localparam logic [5:0] ADDR_FSEL_LAST  = 6'd5;
    localparam logic [5:0] ADDR_SET0       = 6'd7;
    localparam logic [5:0] ADDR_SET1       = 6'd8;
    localparam logic [5:0] ADDR_CLR0       = 6'd10;
    localparam logic [5:0] ADDR_CLR1       = 6'd11;
    localparam logic [5:0] ADDR_LEV0       = 6'd13;
    localparam logic [5:0] ADDR_LEV1       = 6'd14;
    localparam logic [5:0] ADDR_EDS0       = 6'd16;
    localparam logic [5:0] ADDR_EDS1       = 6'd17;
    localparam logic [5:0] ADDR_AREN0      = 6'd31;
    localparam logic [5:0] ADDR_AREN1      = 6'd32;
    localparam logic [5:0] ADDR_AFEN0      = 6'd34;
    localparam logic [5:0] ADDR_AFEN1      = 6'd35;
    localparam logic [5:0] ADDR_PUD        = 6'd37;
    localparam logic [5:0] ADDR_PUDCLK0    = 6'd38;
    localparam logic [5:0] ADDR_PUDCLK1    = 6'd39;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_SAMPLE = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  reg_addr;
        logic [31:0] write_data;
        logic [63:0] pin_levels;
    } t_gpio_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [63:0] out_value;
        logic [63:0] out_enable;
        logic [63:0] pull_up_en;
        logic [63:0] pull_down_en;
        logic        irq;
    } t_gpio_out;

    function automatic logic [63:0] place_half(input logic [31:0] d, input logic hi);
        return hi ? {d, 32'd0} : {32'd0, d};
    endfunction

    function automatic logic [31:0] half_of(input logic [63:0] v, input logic hi);
        return hi ? v[63:32] : v[31:0];
    endfunction

    function automatic logic [63:0] replace_half(input logic [63:0] v, input logic [31:0] d,
                                                 input logic hi);
        return hi ? {d, v[31:0]} : {v[63:32], d};
    endfunction

    // fields of pins that exist within one fsel word
    function automatic logic [FSEL_BITS-1:0] fsel_mask(input int w, input int num_pins);
        logic [FSEL_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < PINS_PER_FSEL; i++) begin
            if (w * PINS_PER_FSEL + i < num_pins) begin
                m[3*i +: 3] = 3'b111;
            end
        end
        return m;
    endfunction

endpackage

@@ hdl/gpioed_core.sv @@
module gpioed_core #(
    parameter int NUM_PINS = gpioed_pkg::NUM_PINS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  gpioed_pkg::t_gpio_in  i_item,
    output gpioed_pkg::t_gpio_out o_result
);
    import gpioed_pkg::*;

    localparam logic [63:0] PinMask = {64{1'b1}} >> (64 - NUM_PINS);

    logic [FSEL_BITS-1:0] r_fsel [FSEL_WORDS];
    logic [FSEL_BITS-1:0] n_fsel [FSEL_WORDS];
    logic [1:0]           r_pull [NUM_PINS];
    logic [1:0]           n_pull [NUM_PINS];
    logic [63:0]          r_out, n_out;
    logic [63:0]          r_rise, n_rise;
    logic [63:0]          r_fall, n_fall;
    logic [63:0]          r_eds, n_eds;
    logic [63:0]          r_prev, n_prev;
    logic [1:0]           r_pud, n_pud;

    logic [5:0]  addr;
    logic [31:0] data;
    logic [63:0] placed;
    logic [63:0] now_lv;
    logic [31:0] rd;
    logic [63:0] oe, pu, pd;

    assign addr   = i_item.reg_addr;
    assign data   = i_item.write_data;
    assign now_lv = i_item.pin_levels & PinMask;

    // half-word placement: the second word of each pair covers pins 32 and up
    always_comb begin
        logic hi;
        hi = (addr == ADDR_SET1) || (addr == ADDR_CLR1) || (addr == ADDR_EDS1) ||
             (addr == ADDR_PUDCLK1);
        placed = place_half(data, hi) & PinMask;
    end

    always_comb begin
        n_fsel = r_fsel;
        n_pull = r_pull;
        n_out  = r_out;
        n_rise = r_rise;
        n_fall = r_fall;
        n_eds  = r_eds;
        n_prev = r_prev;
        n_pud  = r_pud;
        rd     = '0;
        if (i_valid) begin
            case (i_item.cmd)
                CMD_READ: begin
                    case (addr) inside
                        [ADDR_FSEL_FIRST:ADDR_FSEL_LAST]: rd = {2'b00, r_fsel[addr[2:0]]};
                        ADDR_LEV0, ADDR_LEV1:   rd = half_of(r_prev, addr == ADDR_LEV1);
                        ADDR_EDS0, ADDR_EDS1:   rd = half_of(r_eds, addr == ADDR_EDS1);
                        ADDR_AREN0, ADDR_AREN1: rd = half_of(r_rise, addr == ADDR_AREN1);
                        ADDR_AFEN0, ADDR_AFEN1: rd = half_of(r_fall, addr == ADDR_AFEN1);
                        ADDR_PUD:               rd = {30'd0, r_pud};
                        default:                rd = '0;
                    endcase
                end
                CMD_WRITE: begin
                    case (addr) inside
                        [ADDR_FSEL_FIRST:ADDR_FSEL_LAST]: begin
                            for (int w = 0; w < FSEL_WORDS; w++) begin
                                if (addr[2:0] == 3'(w)) begin
                                    n_fsel[w] = data[FSEL_BITS-1:0] & fsel_mask(w, NUM_PINS);
                                end
                            end
                        end
                        ADDR_SET0, ADDR_SET1: n_out = r_out | placed;
                        ADDR_CLR0, ADDR_CLR1: n_out = r_out & ~placed;
                        ADDR_EDS0, ADDR_EDS1: n_eds = r_eds & ~placed;
                        ADDR_AREN0, ADDR_AREN1:
                            n_rise = replace_half(r_rise, data, addr == ADDR_AREN1) & PinMask;
                        ADDR_AFEN0, ADDR_AFEN1:
                            n_fall = replace_half(r_fall, data, addr == ADDR_AFEN1) & PinMask;
                        ADDR_PUD: n_pud = data[1:0];
                        ADDR_PUDCLK0, ADDR_PUDCLK1: begin
                            for (int p = 0; p < NUM_PINS; p++) begin
                                if (placed[p]) begin
                                    n_pull[p] = r_pud;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_SAMPLE: begin
                    n_eds  = (r_eds | (now_lv & ~r_prev & r_rise) |
                              (~now_lv & r_prev & r_fall)) & PinMask;
                    n_prev = now_lv;
                end
                default: ;
            endcase
        end
    end

    // per-pin decode of the state after this item
    always_comb begin
        oe = '0;
        pu = '0;
        pd = '0;
        for (int p = 0; p < NUM_PINS; p++) begin
            if (p < FSEL_PINS) begin
                oe[p] = n_fsel[p / PINS_PER_FSEL][3*(p % PINS_PER_FSEL) +: 3] == FSEL_OUTPUT;
            end
            pu[p] = n_pull[p] == PULL_UP;
            pd[p] = n_pull[p] == PULL_DOWN;
        end
    end

    always_comb begin
        o_result.read_data    = rd;
        o_result.out_value    = n_out;
        o_result.out_enable   = oe;
        o_result.pull_up_en   = pu;
        o_result.pull_down_en = pd;
        o_result.irq          = |n_eds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < FSEL_WORDS; w++) begin
                r_fsel[w] <= '0;
            end
            for (int p = 0; p < NUM_PINS; p++) begin
                r_pull[p] <= '0;
            end
            r_out  <= '0;
            r_rise <= '0;
            r_fall <= '0;
            r_eds  <= '0;
            r_prev <= '0;
            r_pud  <= '0;
        end else begin
            r_fsel <= n_fsel;
            r_pull <= n_pull;
            r_out  <= n_out;
            r_rise <= n_rise;
            r_fall <= n_fall;
            r_eds  <= n_eds;
            r_prev <= n_prev;
            r_pud  <= n_pud;
        end
    end

endmodule

@@ hdl/gpio_controller_edge_detect.sv @@
// GPIO controller with edge detection. Each item is a bus read, a bus write or a
// pin sample; one item is accepted in every clock cycle (busy stays low). An item
// is held in the input register, where the update logic works out the new pin
// state and the result. The next edge writes the pin state and loads the result
// register, and o_done, registered alongside it, marks o_result. Items see the
// state left by the item before them. The receiver cannot stall, so every result
// is present for exactly one cycle and must be taken then.
module gpio_controller_edge_detect #(
    parameter int NUM_PINS = gpioed_pkg::NUM_PINS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  gpioed_pkg::t_gpio_in  i_item,
    output logic                  o_done,
    output gpioed_pkg::t_gpio_out o_result
);
    import gpioed_pkg::*;

    localparam logic [63:0] PinMask = {64{1'b1}} >> (64 - NUM_PINS);

    logic      r_in_valid;
    t_gpio_in  r_item;
    logic      r_done;
    t_gpio_out r_result;
    t_gpio_out core_result;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
        end
        if (r_in_valid) begin
            r_result <= core_result;
        end
    end

    gpioed_core #(
        .NUM_PINS(NUM_PINS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_item),
        .o_result(core_result)
    );

    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_done)
        else $error("item accepted without a result two cycles later");

    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && ($past(r_item.cmd) != CMD_READ) |-> o_result.read_data == '0)
        else $error("nonzero read data for a non-read item");

    a_missing_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.out_value | o_result.out_enable | o_result.pull_up_en |
                     o_result.pull_down_en) & ~PinMask) == '0)
        else $error("bits set for pins that do not exist");

endmodule

@@ dv/gpio_controller_edge_detect_test.sv @@
`timescale 1ns / 100ps

module gpio_controller_edge_detect_test;
    import gpioed_pkg::*;

    localparam int PINS = NUM_PINS_DEFAULT;
    localparam logic [63:0] PIN_MASK = (PINS >= 64) ? '1 : ((64'd1 << PINS) - 64'd1);
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 11;
    localparam int LATENCY = 2;
    localparam int TIMEOUT_CYCLES = 100000;
    localparam int PHASE_ITEMS = 310;

    class gpio_shadow;
        logic [2:0]  fsel_field [PINS];
        logic [1:0]  pin_pull [PINS];
        logic [63:0] out_latch;
        logic [63:0] rise_en;
        logic [63:0] fall_en;
        logic [63:0] event_bits;
        logic [63:0] last_sampled;
        logic [1:0]  pull_word;
        t_gpio_out   predicted_outputs [$];
        int          errors;

        function new();
            for (int p = 0; p < PINS; p++) begin
                fsel_field[p] = '0;
                pin_pull[p]   = '0;
            end
            out_latch    = '0;
            rise_en      = '0;
            fall_en      = '0;
            event_bits   = '0;
            last_sampled = '0;
            pull_word    = '0;
            errors       = 0;
        endfunction

        // place a bus word on the low or high pins
        function logic [63:0] spread(input logic [31:0] d, input logic upper);
            return ({32'd0, d} << (upper ? 32 : 0)) & PIN_MASK;
        endfunction

        function logic [31:0] pick_word(input logic [63:0] v, input logic upper);
            logic [63:0] shifted;
            shifted = v >> (upper ? 32 : 0);
            return shifted[31:0];
        endfunction

        function int pending();
            return predicted_outputs.size();
        endfunction

        function void apply_item(input t_gpio_in it);
            t_gpio_out   r;
            logic [31:0] rd;
            logic [63:0] sel;
            logic [63:0] now;
            logic [5:0]  a;
            int          pin;
            rd = '0;
            a  = it.reg_addr;
            case (it.cmd)
                CMD_READ: begin
                    if (a <= ADDR_FSEL_LAST) begin
                        for (int i = 0; i < PINS_PER_FSEL; i++) begin
                            pin = int'(a) * PINS_PER_FSEL + i;
                            if (pin < PINS) rd[3*i +: 3] = fsel_field[pin];
                        end
                    end else begin
                        case (a)
                            ADDR_LEV0, ADDR_LEV1: rd = pick_word(last_sampled, a == ADDR_LEV1);
                            ADDR_EDS0, ADDR_EDS1: rd = pick_word(event_bits, a == ADDR_EDS1);
                            ADDR_AREN0, ADDR_AREN1: rd = pick_word(rise_en, a == ADDR_AREN1);
                            ADDR_AFEN0, ADDR_AFEN1: rd = pick_word(fall_en, a == ADDR_AFEN1);
                            ADDR_PUD: rd = {30'd0, pull_word};
                            default: rd = '0;
                        endcase
                    end
                end
                CMD_WRITE: begin
                    if (a <= ADDR_FSEL_LAST) begin
                        for (int i = 0; i < PINS_PER_FSEL; i++) begin
                            pin = int'(a) * PINS_PER_FSEL + i;
                            if (pin < PINS) fsel_field[pin] = it.write_data[3*i +: 3];
                        end
                    end else begin
                        case (a)
                            ADDR_SET0, ADDR_SET1:
                                out_latch |= spread(it.write_data, a == ADDR_SET1);
                            ADDR_CLR0, ADDR_CLR1:
                                out_latch &= ~spread(it.write_data, a == ADDR_CLR1);
                            ADDR_EDS0, ADDR_EDS1:
                                event_bits &= ~spread(it.write_data, a == ADDR_EDS1);
                            ADDR_AREN0, ADDR_AREN1:
                                rise_en = (rise_en & ~spread('1, a == ADDR_AREN1))
                                          | spread(it.write_data, a == ADDR_AREN1);
                            ADDR_AFEN0, ADDR_AFEN1:
                                fall_en = (fall_en & ~spread('1, a == ADDR_AFEN1))
                                          | spread(it.write_data, a == ADDR_AFEN1);
                            ADDR_PUD: pull_word = it.write_data[1:0];
                            ADDR_PUDCLK0, ADDR_PUDCLK1: begin
                                sel = spread(it.write_data, a == ADDR_PUDCLK1);
                                for (int p = 0; p < PINS; p++) begin
                                    if (sel[p]) pin_pull[p] = pull_word;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_SAMPLE: begin
                    now = it.pin_levels & PIN_MASK;
                    event_bits |= (now & ~last_sampled & rise_en)
                                  | (~now & last_sampled & fall_en);
                    event_bits &= PIN_MASK;
                    last_sampled = now;
                end
                default: ;
            endcase

            r = '0;
            r.read_data = rd;
            r.out_value = out_latch & PIN_MASK;
            for (int p = 0; p < PINS; p++) begin
                r.out_enable[p]   = (fsel_field[p] == FSEL_OUTPUT);
                r.pull_up_en[p]   = (pin_pull[p] == PULL_UP);
                r.pull_down_en[p] = (pin_pull[p] == PULL_DOWN);
            end
            r.irq = (event_bits != 0);
            predicted_outputs.push_back(r);
        endfunction

        function void check_field(input string name, input logic [63:0] e,
                                  input logic [63:0] g);
            if (g !== e) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, g);
            end
        endfunction

        function void compare_output(input t_gpio_out got);
            t_gpio_out e;
            if (predicted_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual %h", $realtime, got);
                return;
            end
            e = predicted_outputs.pop_front();
            check_field("read_data", 64'(e.read_data), 64'(got.read_data));
            check_field("out_value", e.out_value, got.out_value);
            check_field("out_enable", e.out_enable, got.out_enable);
            check_field("pull_up_en", e.pull_up_en, got.pull_up_en);
            check_field("pull_down_en", e.pull_down_en, got.pull_down_en);
            check_field("irq", 64'(e.irq), 64'(got.irq));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_gpio_in  i_item = '0;
    logic      o_done;
    t_gpio_out o_result;

    gpio_shadow  shadow = new();
    logic [63:0] pad_levels = '0;

    gpio_controller_edge_detect DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) shadow.compare_output(o_result);
    end

    function automatic t_gpio_in make_item(input logic [1:0] c, input logic [5:0] a,
                                           input logic [31:0] d, input logic [63:0] lv);
        t_gpio_in it;
        it.cmd        = c;
        it.reg_addr   = a;
        it.write_data = d;
        it.pin_levels = lv;
        return it;
    endfunction

    function automatic logic [5:0] pick_addr();
        logic upper;
        upper = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: return 6'($urandom_range(0, 5));
            1: return upper ? ADDR_SET1 : ADDR_SET0;
            2: return upper ? ADDR_CLR1 : ADDR_CLR0;
            3: return upper ? ADDR_LEV1 : ADDR_LEV0;
            4: return upper ? ADDR_EDS1 : ADDR_EDS0;
            5: return upper ? ADDR_AREN1 : ADDR_AREN0;
            6: return upper ? ADDR_AFEN1 : ADDR_AFEN0;
            7: return ADDR_PUD;
            8: return upper ? ADDR_PUDCLK1 : ADDR_PUDCLK0;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_gpio_in random_item();
        logic [63:0] flips;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return make_item(CMD_WRITE, pick_addr(), pick_data(),
                                        {$urandom, $urandom});
        if (roll < 60) begin
            // toggle a random subset of pins, sparse half the time
            flips = {$urandom, $urandom};
            if ($urandom_range(0, 1)) flips &= {$urandom, $urandom};
            pad_levels ^= flips;
            return make_item(CMD_SAMPLE, 6'($urandom_range(0, 63)), $urandom, pad_levels);
        end
        if (roll < 85) return make_item(CMD_READ, pick_addr(), $urandom,
                                        {$urandom, $urandom});
        if (roll < 95) return make_item(2'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                                        $urandom, {$urandom, $urandom});
        return make_item(CMD_UNUSED, 6'($urandom_range(0, 63)), $urandom,
                         {$urandom, $urandom});
    endfunction

    task automatic send_item(input t_gpio_in it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        shadow.apply_item(it);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input int idle_pct);
        for (int k = 0; k < n_items; k++) begin
            // leave every third stretch of 32 items without gaps
            if (idle_pct > 0 && (k / 32) % 3 != 0 && $urandom_range(0, 99) < idle_pct)
                hold_off($urandom_range(1, 3));
            send_item(random_item());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(make_item(CMD_WRITE, ADDR_FSEL_FIRST, '1, '0));
        send_item(make_item(CMD_READ, ADDR_FSEL_FIRST, '0, '0));
        send_item(make_item(CMD_WRITE, ADDR_FSEL_LAST, 32'h0924_9249, '0));
        send_item(make_item(CMD_WRITE, ADDR_SET0, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_SET1, '1, '0));
        send_item(make_item(CMD_READ, ADDR_SET1, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_CLR1, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_AREN0, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_AREN1, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_AFEN1, '1, '0));
        send_item(make_item(CMD_SAMPLE, ADDR_FSEL_FIRST, '0, '1));
        send_item(make_item(CMD_READ, ADDR_EDS1, '0, '0));
        send_item(make_item(CMD_WRITE, ADDR_AFEN0, '1, '0));
        send_item(make_item(CMD_SAMPLE, ADDR_FSEL_FIRST, '0, '0));
        send_item(make_item(CMD_WRITE, ADDR_LEV0, '1, '1));
        send_item(make_item(CMD_WRITE, ADDR_EDS0, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_EDS1, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_PUD, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_PUDCLK0, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_PUD, 32'd2, '0));
        send_item(make_item(CMD_WRITE, ADDR_PUDCLK1, '1, '0));
        send_item(make_item(CMD_WRITE, ADDR_PUD, 32'd1, '0));
        send_item(make_item(CMD_WRITE, ADDR_PUDCLK0, 32'h0000_F0F0, '0));
        send_item(make_item(CMD_WRITE, 6'd63, '1, '1));
        send_item(make_item(CMD_UNUSED, 6'd20, '1, '1));
        drain();

        run_phase(PHASE_ITEMS, 0);
        drain();
        run_phase(PHASE_ITEMS, 66);
        drain();
        run_phase(PHASE_ITEMS, 0);
        drain();
        run_phase(PHASE_ITEMS, 19);
        drain();

        repeat (LATENCY + 4) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
